### design/ugrt_pkg.sv
// Shared types, constants and helpers of the uniform grid ray traversal core.
package ugrt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int MAX_CELLS_DEF = 128;

   localparam int CELL_W      = 8;
   localparam int RES_W       = 8;
   localparam int RES_FIELD_W = 7;
   localparam int TIME_W      = 32;
   localparam int COORD_W     = 32;
   localparam int SIZE_W      = 31;
   localparam int RESP_W      = 21;
   localparam int HIT_W       = 31;
   localparam int NUM_W       = 49;   // signed positions and quotient numerators
   localparam int DEN_W       = 33;   // signed quotient denominators
   localparam int T_W         = 53;   // signed ray distances
   localparam int DIV_SAT_LOG = 50;
   localparam int QBITS       = DIV_SAT_LOG + 1;
   localparam int IDX_W       = 21;
   localparam int PROD_W      = 64;
   localparam int ENTRY_LIMIT = 10000;

   localparam int REQ_DATA_W  = 224;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [TIME_W-1:0] TIME_SAT = '1;
   localparam logic [HIT_W-1:0]  HIT_NONE = '1;

   typedef logic signed [T_W-1:0]   time_type;
   typedef logic signed [NUM_W-1:0] num_type;
   typedef logic signed [DEN_W-1:0] den_type;

   typedef enum logic [0:0] {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_CELL = 2'd0,
      ST_MISS = 2'd1,
      ST_LEFT = 2'd2,
      ST_HIT  = 2'd3
   } status_type;

   localparam logic [CSR_ADDR_W-1:0] REG_MIN_X  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_Y  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_Z  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SIZE_X = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SIZE_Y = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SIZE_Z = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_RES    = 3'd6;

   // axis of the nearest crossing, indexed by {c0<c1, c0<c2, c1<c2}
   localparam logic [1:0] AXIS_PICK [8] = '{2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd0, 2'd0};

   typedef struct packed {
      logic    start;
      num_type num;
      den_type den;
   } div_req_type;

   typedef struct packed {
      logic     done;
      time_type quo;
   } div_rsp_type;

   // clamp a distance into the stored unsigned range
   function automatic logic [TIME_W-1:0] sat_time(input time_type v);
      logic [TIME_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({{(T_W-TIME_W){1'b0}}, TIME_SAT})) begin
         r = TIME_SAT;
      end else begin
         r = v[TIME_W-1:0];
      end
      return r;
   endfunction

endpackage

### design/uniform_grid_ray_traversal_core.sv
// Top level of the uniform grid ray traversal core: sequencer, state and ports.
//
// Walks a ray through a uniform 3D grid of cells, one cell per advance transaction.
// req channel: tuser holds the operation (start or advance), tdata the ray and the
// nearest hit distance. rsp channel: one transaction per request with the cell
// index in tdata and the status in tuser. csr port: registers are written at any
// edge with csr_we high; write them only while the core is idle, which the block
// itself does not enforce. A start transaction runs through the shared multiplier
// and the shared bit-serial divider: three box products, two divisions per moving
// axis for the slab test, at most one division per axis for the entry cell and two
// per moving axis for delta and first crossing. A miss answers once the box products
// or the slab test decide it. An advance passes the axis pick and step, then the
// two-stage index unit and the output register; a hit or an exit skips the index
// unit. The next request is taken once the sequencer has passed the result on.
// req_tready is high only while the sequencer is idle; a finished result waits in
// the output register while the next request may already be accepted, and the
// sequencer holds a new result until the receiver takes the old one.
// Reset clears the walk, the sequencer and the output valid, and loads the register
// defaults (unit cells, one cell per axis, grid corner at the origin).
module uniform_grid_ray_traversal_core
   import ugrt_pkg::*;
#(
   parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEF,
   parameter int FRACTION_BITS      = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, best_hit, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cell_index, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam time_type T_LOW   = {1'b1, {(T_W-1){1'b0}}};
   localparam time_type T_HIGH  = {1'b0, {(T_W-1){1'b1}}};
   localparam time_type T_LIMIT = time_type'(ENTRY_LIMIT) <<< FRACTION_BITS;
   localparam logic [RES_W-1:0] RES_MAX = RES_W'(MAX_CELLS_PER_AXIS);

   typedef enum logic [4:0] {
      S_IDLE, S_ADV, S_IDX_GO, S_IDX_WAIT, S_OUT,
      S_HI_MUL, S_HI_ADD, S_SLAB_A, S_SLAB_AW, S_SLAB_BW, S_CHECK,
      S_P_MUL_I, S_P_MUL_F, S_P_ADD, S_CELL, S_CELL_W, S_AXIS,
      S_DELTA_W, S_NUM_MUL, S_CROSS_W
   } state_type;

   // configuration registers
   logic signed [COORD_W-1:0] gmin_ff [3];
   logic [SIZE_W-1:0]         csize_ff [3];
   logic [RESP_W-1:0]         resp_ff;

   // sequencer and walk state
   state_type                 state_ff, state_in;
   logic [1:0]                ax_ff, ax_in;
   logic                      active_ff, active_in;
   logic [CELL_W-1:0]         cell_ff [3];
   logic [CELL_W-1:0]         cell_in [3];
   logic                      neg_ff [3];
   logic                      neg_in [3];
   logic [TIME_W-1:0]         cross_ff [3];
   logic [TIME_W-1:0]         cross_in [3];
   logic [TIME_W-1:0]         delta_ff [3];
   logic [TIME_W-1:0]         delta_in [3];
   logic signed [COORD_W-1:0] o_ff [3];
   logic signed [COORD_W-1:0] o_in [3];
   logic signed [COORD_W-1:0] d_ff [3];
   logic signed [COORD_W-1:0] d_in [3];
   num_type                   hi_ff [3];
   num_type                   hi_in [3];
   logic [HIT_W-1:0]          hit_ff, hit_in;
   time_type                  tnear_ff, tnear_in;
   time_type                  tfar_ff, tfar_in;
   time_type                  tmin_ff, tmin_in;
   time_type                  ta_ff, ta_in;
   logic [PROD_W-1:0]         pti_ff, pti_in;
   num_type                   rel_ff, rel_in;
   status_type                stat_ff, stat_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]          rsp_index_ff, rsp_index_in;
   status_type                rsp_status_ff, rsp_status_in;

   // shared units
   logic                      mul_en;
   logic [31:0]               mul_a, mul_b;
   logic [PROD_W-1:0]         mul_prod;
   div_req_type               div_req;
   div_rsp_type               div_rsp;
   logic                      idx_start, idx_done;
   logic [IDX_W-1:0]          idx_index;

   // per-axis views
   logic [RES_W-1:0]          res [3];
   logic [SIZE_W-1:0]         cs [3];
   logic signed [COORD_W-1:0] d_cur, o_cur, lo_cur;
   num_type                   hi_cur;
   logic [SIZE_W-1:0]         cs_cur;
   logic [RES_W-1:0]          res_cur;
   logic [COORD_W-1:0]        d_mag;
   logic [2:0]                pick_k;
   logic [1:0]                pick_a;
   logic [TIME_W:0]           step_sum;
   logic [PROD_W-1:0]         p_sum;
   time_type                  n_t, f_t, t_pos;
   logic [T_W-1:0]            cell_q;
   logic [CELL_W:0]           cell_up;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         res[i] = (RES_W'(resp_ff[RES_FIELD_W*i +: RES_FIELD_W]) + RES_W'(1) > RES_MAX)
                  ? RES_MAX
                  : RES_W'(resp_ff[RES_FIELD_W*i +: RES_FIELD_W]) + RES_W'(1);
         cs[i]  = (csize_ff[i] == '0) ? SIZE_W'(1) : csize_ff[i];
      end
      d_cur   = d_ff[ax_ff];
      o_cur   = o_ff[ax_ff];
      lo_cur  = gmin_ff[ax_ff];
      hi_cur  = hi_ff[ax_ff];
      cs_cur  = cs[ax_ff];
      res_cur = res[ax_ff];
      d_mag   = d_cur[COORD_W-1] ? COORD_W'(-d_cur) : COORD_W'(d_cur);
      pick_k  = {cross_ff[0] < cross_ff[1], cross_ff[0] < cross_ff[2],
                 cross_ff[1] < cross_ff[2]};
      pick_a  = AXIS_PICK[pick_k];
      step_sum = (TIME_W+1)'(cross_ff[pick_a]) + (TIME_W+1)'(delta_ff[pick_a]);
      p_sum   = pti_ff + (mul_prod >> FRACTION_BITS);
      n_t     = (ta_ff < div_rsp.quo) ? ta_ff : div_rsp.quo;
      f_t     = (ta_ff < div_rsp.quo) ? div_rsp.quo : ta_ff;
      t_pos   = (div_rsp.quo < 0) ? '0 : div_rsp.quo;
      cell_q  = div_rsp.quo >> FRACTION_BITS;
      cell_up = neg_ff[ax_ff] ? (CELL_W+1)'(cell_ff[ax_ff])
                              : (CELL_W+1)'(cell_ff[ax_ff]) + (CELL_W+1)'(1);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            gmin_ff[i]  <= '0;
            csize_ff[i] <= SIZE_W'(65536);
         end
         resp_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MIN_X:  gmin_ff[0]  <= csr_wdata;
            REG_MIN_Y:  gmin_ff[1]  <= csr_wdata;
            REG_MIN_Z:  gmin_ff[2]  <= csr_wdata;
            REG_SIZE_X: csize_ff[0] <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Y: csize_ff[1] <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Z: csize_ff[2] <= csr_wdata[SIZE_W-1:0];
            REG_RES:    resp_ff     <= csr_wdata[RESP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      ax_in     = ax_ff;
      active_in = active_ff;
      cell_in   = cell_ff;
      neg_in    = neg_ff;
      cross_in  = cross_ff;
      delta_in  = delta_ff;
      o_in      = o_ff;
      d_in      = d_ff;
      hi_in     = hi_ff;
      hit_in    = hit_ff;
      tnear_in  = tnear_ff;
      tfar_in   = tfar_ff;
      tmin_in   = tmin_ff;
      ta_in     = ta_ff;
      pti_in    = pti_ff;
      rel_in    = rel_ff;
      stat_in   = stat_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_req   = '0;
      idx_start = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 3; i++) begin
                  o_in[i] = req_tdata[COORD_W*i +: COORD_W];
                  d_in[i] = req_tdata[COORD_W*(i+3) +: COORD_W];
               end
               hit_in = req_tdata[COORD_W*6 +: HIT_W];
               if (req_tuser[0] == OP_ADVANCE) begin
                  state_in = S_ADV;
               end else begin
                  active_in = 1'b0;
                  ax_in     = '0;
                  tnear_in  = T_LOW;
                  tfar_in   = T_HIGH;
                  state_in  = S_HI_MUL;
               end
            end
         end
         S_ADV: begin
            if (!active_ff) begin
               stat_in  = ST_LEFT;
               state_in = S_OUT;
            end else if (hit_ff != HIT_NONE && {1'b0, hit_ff} < cross_ff[pick_a]) begin
               active_in = 1'b0;
               stat_in   = ST_HIT;
               state_in  = S_OUT;
            end else if (neg_ff[pick_a] ? (cell_ff[pick_a] == '0)
                         : (RES_W'(cell_ff[pick_a]) + RES_W'(1) >= res[pick_a])) begin
               active_in = 1'b0;
               stat_in   = ST_LEFT;
               state_in  = S_OUT;
            end else begin
               cell_in[pick_a]  = neg_ff[pick_a] ? cell_ff[pick_a] - CELL_W'(1)
                                                 : cell_ff[pick_a] + CELL_W'(1);
               cross_in[pick_a] = step_sum[TIME_W] ? TIME_SAT : step_sum[TIME_W-1:0];
               stat_in  = ST_CELL;
               state_in = S_IDX_GO;
            end
         end
         S_IDX_GO: begin
            idx_start = 1'b1;
            state_in  = S_IDX_WAIT;
         end
         S_IDX_WAIT: begin
            if (idx_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = (stat_ff == ST_CELL) ? idx_index : '0;
               rsp_status_in = stat_ff;
               state_in      = S_IDLE;
            end
         end
         // upper box corner per axis
         S_HI_MUL: begin
            mul_en   = 1'b1;
            mul_a    = 32'(res_cur);
            mul_b    = 32'(cs_cur);
            state_in = S_HI_ADD;
         end
         S_HI_ADD: begin
            hi_in[ax_ff] = NUM_W'(lo_cur) + $signed({1'b0, mul_prod[NUM_W-2:0]});
            if (ax_ff == 2'd2) begin
               ax_in = '0;
               if (d_ff[0] == '0 && d_ff[1] == '0 && d_ff[2] == '0) begin
                  stat_in  = ST_MISS;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SLAB_A;
               end
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_HI_MUL;
            end
         end
         // slab test
         S_SLAB_A: begin
            if (d_cur == '0) begin
               if (o_cur < lo_cur || NUM_W'(o_cur) > hi_cur) begin
                  stat_in  = ST_MISS;
                  state_in = S_OUT;
               end else if (ax_ff == 2'd2) begin
                  state_in = S_CHECK;
               end else begin
                  ax_in = ax_ff + 2'd1;
               end
            end else begin
               div_req.start = 1'b1;
               div_req.num   = NUM_W'(lo_cur) - NUM_W'(o_cur);
               div_req.den   = DEN_W'(d_cur);
               state_in      = S_SLAB_AW;
            end
         end
         S_SLAB_AW: begin
            if (div_rsp.done) begin
               ta_in         = div_rsp.quo;
               div_req.start = 1'b1;
               div_req.num   = hi_cur - NUM_W'(o_cur);
               div_req.den   = DEN_W'(d_cur);
               state_in      = S_SLAB_BW;
            end
         end
         S_SLAB_BW: begin
            if (div_rsp.done) begin
               if (n_t > tnear_ff) tnear_in = n_t;
               if (f_t < tfar_ff) tfar_in = f_t;
               if (ax_ff == 2'd2) begin
                  state_in = S_CHECK;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_SLAB_A;
               end
            end
         end
         S_CHECK: begin
            if (tnear_ff > tfar_ff || tfar_ff < 0 || tnear_ff > T_LIMIT) begin
               stat_in  = ST_MISS;
               state_in = S_OUT;
            end else begin
               tmin_in  = (tnear_ff > 0) ? tnear_ff : '0;
               ax_in    = '0;
               state_in = S_P_MUL_I;
            end
         end
         // entry point: integer part of tmin first, then the fraction
         S_P_MUL_I: begin
            if (tmin_ff > 0) begin
               mul_en   = 1'b1;
               mul_a    = d_mag;
               mul_b    = 32'(tmin_ff[T_W-1:FRACTION_BITS]);
               state_in = S_P_MUL_F;
            end else begin
               rel_in   = NUM_W'(o_cur) - NUM_W'(lo_cur);
               state_in = S_CELL;
            end
         end
         S_P_MUL_F: begin
            pti_in   = mul_prod;
            mul_en   = 1'b1;
            mul_a    = d_mag;
            mul_b    = 32'(tmin_ff[FRACTION_BITS-1:0]);
            state_in = S_P_ADD;
         end
         S_P_ADD: begin
            if (d_cur[COORD_W-1]) begin
               rel_in = NUM_W'(o_cur) - $signed({1'b0, p_sum[NUM_W-2:0]}) - NUM_W'(lo_cur);
            end else begin
               rel_in = NUM_W'(o_cur) + $signed({1'b0, p_sum[NUM_W-2:0]}) - NUM_W'(lo_cur);
            end
            state_in = S_CELL;
         end
         S_CELL: begin
            neg_in[ax_ff] = d_cur[COORD_W-1];
            if (rel_ff < 0) begin
               cell_in[ax_ff] = '0;
               state_in       = S_AXIS;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = rel_ff;
               div_req.den   = $signed({2'b0, cs_cur});
               state_in      = S_CELL_W;
            end
         end
         S_CELL_W: begin
            if (div_rsp.done) begin
               if (cell_q > T_W'(res_cur - RES_W'(1))) begin
                  cell_in[ax_ff] = CELL_W'(res_cur - RES_W'(1));
               end else begin
                  cell_in[ax_ff] = cell_q[CELL_W-1:0];
               end
               state_in = S_AXIS;
            end
         end
         S_AXIS: begin
            if (d_cur == '0) begin
               delta_in[ax_ff] = TIME_SAT;
               cross_in[ax_ff] = TIME_SAT;
               if (ax_ff == 2'd2) begin
                  active_in = 1'b1;
                  stat_in   = ST_CELL;
                  state_in  = S_IDX_GO;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_P_MUL_I;
               end
            end else begin
               div_req.start = 1'b1;
               div_req.num   = NUM_W'($signed({1'b0, cs_cur}));
               div_req.den   = $signed({1'b0, d_mag});
               state_in      = S_DELTA_W;
            end
         end
         S_DELTA_W: begin
            if (div_rsp.done) begin
               delta_in[ax_ff] = sat_time(div_rsp.quo);
               mul_en   = 1'b1;
               mul_a    = 32'(cell_up);
               mul_b    = 32'(cs_cur);
               state_in = S_NUM_MUL;
            end
         end
         S_NUM_MUL: begin
            div_req.start = 1'b1;
            div_req.num   = $signed({1'b0, mul_prod[NUM_W-2:0]}) - rel_ff;
            div_req.den   = DEN_W'(d_cur);
            state_in      = S_CROSS_W;
         end
         S_CROSS_W: begin
            if (div_rsp.done) begin
               cross_in[ax_ff] = sat_time(tmin_ff + t_pos);
               if (ax_ff == 2'd2) begin
                  active_in = 1'b1;
                  stat_in   = ST_CELL;
                  state_in  = S_IDX_GO;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_P_MUL_I;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ax_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         ax_ff        <= ax_in;
      end
      cell_ff  <= cell_in;
      neg_ff   <= neg_in;
      cross_ff <= cross_in;
      delta_ff <= delta_in;
      o_ff     <= o_in;
      d_ff     <= d_in;
      hi_ff    <= hi_in;
      hit_ff   <= hit_in;
      tnear_ff <= tnear_in;
      tfar_ff  <= tfar_in;
      tmin_ff  <= tmin_in;
      ta_ff    <= ta_in;
      pti_ff   <= pti_in;
      rel_ff   <= rel_in;
      stat_ff  <= stat_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   ugrt_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   ugrt_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   ugrt_idx u_idx (
      .clock  (clock),
      .reset  (reset),
      .start  (idx_start),
      .cell_x (cell_ff[0]),
      .cell_y (cell_ff[1]),
      .cell_z (cell_ff[2]),
      .res_x  (res[0]),
      .res_y  (res[1]),
      .done   (idx_done),
      .index  (idx_index)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-IDX_W){1'b0}}, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

### design/ugrt_div.sv
// Shared fixed-point divider: one quotient bit per cycle, saturating at 2^50.
module ugrt_div
   import ugrt_pkg::*;
#(
   parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int NDW   = NUM_W + FRACTION_BITS;
   localparam int CNT_W = $clog2(QBITS + 1);
   localparam logic [QBITS-1:0] SAT_MAG = {1'b1, {(QBITS-1){1'b0}}};

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} dstate_type;

   dstate_type        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [QBITS-1:0]  num_ff, num_in;
   logic [QBITS-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic              sat_ff, sat_in;
   logic              done_ff, done_in;
   time_type          res_ff, res_in;

   logic [NUM_W-1:0]  a_mag;
   logic [DEN_W-1:0]  b_mag;
   logic [NDW-1:0]    n_full;
   logic [NDW-1:0]    n_hi;
   logic              ovf;
   logic [DEN_W:0]    trial;
   logic [QBITS-1:0]  q_mag;

   always_comb begin
      a_mag  = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
      b_mag  = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
      n_full = NDW'(a_mag) << FRACTION_BITS;
      n_hi   = n_full >> QBITS;
      ovf    = (b_mag == '0) || (n_hi >= NDW'(b_mag));
      trial  = {rem_ff[DEN_W-1:0], num_ff[QBITS-1]};
      q_mag  = (sat_ff || (quo_ff > SAT_MAG)) ? SAT_MAG : quo_ff;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      done_in  = 1'b0;
      res_in   = res_ff;

      unique case (state_ff)
         D_IDLE: begin
            if (req.start) begin
               den_in   = b_mag;
               rem_in   = n_hi[DEN_W:0];
               num_in   = n_full[QBITS-1:0];
               quo_in   = '0;
               neg_in   = req.num[NUM_W-1] ^ req.den[DEN_W-1];
               sat_in   = ovf;
               cnt_in   = CNT_W'(QBITS);
               state_in = ovf ? D_DONE : D_RUN;
            end
         end
         D_RUN: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               quo_in = {quo_ff[QBITS-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[QBITS-2:0], 1'b0};
            end
            num_in = {num_ff[QBITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            res_in   = neg_ff ? -$signed({{(T_W-QBITS){1'b0}}, q_mag})
                              :  $signed({{(T_W-QBITS){1'b0}}, q_mag});
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = res_ff;

endmodule

### design/ugrt_mul.sv
// Shared 32 by 32 multiplier with a registered product.
module ugrt_mul
   import ugrt_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [31:0]       a,
   input  logic [31:0]       b,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = PROD_W'(a) * PROD_W'(b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

### design/ugrt_idx.sv
// Two-stage linear cell index: x + y*resx + z*resx*resy.
module ugrt_idx
   import ugrt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CELL_W-1:0] cell_x,
   input  logic [CELL_W-1:0] cell_y,
   input  logic [CELL_W-1:0] cell_z,
   input  logic [RES_W-1:0]  res_x,
   input  logic [RES_W-1:0]  res_y,
   output logic              done,
   output logic [IDX_W-1:0]  index
);

   logic                      v1_ff, v2_ff;
   logic [CELL_W-1:0]         x_ff, z_ff;
   logic [2*RES_W-1:0]        yrx_ff, yrx_in;
   logic [2*RES_W-1:0]        rxry_ff, rxry_in;
   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W+2:0]          sum_w;

   always_comb begin
      yrx_in  = (2*RES_W)'(cell_y) * (2*RES_W)'(res_x);
      rxry_in = (2*RES_W)'(res_x) * (2*RES_W)'(res_y);
      sum_w   = (IDX_W+3)'(x_ff) + (IDX_W+3)'(yrx_ff)
              + (IDX_W+3)'(z_ff) * (IDX_W+3)'(rxry_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
      if (start) begin
         x_ff    <= cell_x;
         z_ff    <= cell_z;
         yrx_ff  <= yrx_in;
         rxry_ff <= rxry_in;
      end
      if (v1_ff) begin
         idx_ff <= sum_w[IDX_W-1:0];
      end
   end

   assign done  = v2_ff;
   assign index = idx_ff;

endmodule

### dv/tb.sv
// Self-checking testbench for the uniform grid ray traversal core.
module tb;
   import ugrt_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam longint unsigned QSAT = 64'd1 << DIV_SAT_LOG;
   localparam longint ONE = 64'sd1 << FB;
   localparam int N_ITEMS = 1450;

   typedef struct {
      op_type           op;
      logic [31:0]      org [3];
      logic [31:0]      dir [3];
      logic [HIT_W-1:0] hit;
   } ray_req;

   typedef struct {
      ray_req      rq;
      bit          chk;
      logic [20:0] idx;
      status_type  st;
   } dir_row;

   typedef struct {
      logic [20:0] idx;
      status_type  st;
   } cell_result;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // grid registers and walk state as the block should hold them
   longint            grid_lo [3];
   logic [30:0]       cell_len [3];
   logic [20:0]       res_packed;
   logic [7:0]        walk_cell [3];
   bit                walk_neg [3];
   logic [31:0]       cross_at [3];
   logic [31:0]       cross_step [3];
   bit                walking;

   cell_result pending_cells [$];
   int fail_count = 0;
   int sent_count = 0;
   int burst_left = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   bit stall_on = 1'b0;
   logic [7:0] stall_mask = 8'hFF;
   int unsigned cyc = 0;

   uniform_grid_ray_traversal_core DUT (.*);

   always #1 clock = ~clock;

   function automatic longint unsigned mag64(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   function automatic longint q_div(longint n, longint d);
      longint unsigned a, b, q, q0, r;
      a = mag64(n);
      b = mag64(d);
      if (b == 0) begin
         q = QSAT;
      end else begin
         q0 = a / b;
         r  = a % b;
         if (q0 >= (QSAT >> FB)) begin
            q = QSAT;
         end else begin
            q = (q0 << FB) + ((r << FB) / b);
            if (q > QSAT) q = QSAT;
         end
      end
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint q_mul(longint d, longint t);
      longint unsigned m, p;
      m = mag64(d);
      p = m * (t >> FB) + ((m * (t & (ONE - 1))) >> FB);
      return d < 0 ? -longint'(p) : longint'(p);
   endfunction

   function automatic logic [31:0] clamp_dist(longint v);
      if (v < 0) return 32'd0;
      if (v > 64'sh0FFFFFFFF) return 32'hFFFFFFFF;
      return v[31:0];
   endfunction

   function automatic longint axis_cells(int i);
      return longint'((res_packed >> (7 * i)) & 21'h7F) + 1;
   endfunction

   function automatic longint edge_len(int i);
      return cell_len[i] == 0 ? 64'sd1 : longint'(cell_len[i]);
   endfunction

   function automatic logic [20:0] flat_index();
      longint rx, ry, s;
      rx = axis_cells(0);
      ry = axis_cells(1);
      s = walk_cell[0] + walk_cell[1] * rx + walk_cell[2] * rx * ry;
      return s[20:0];
   endfunction

   function automatic cell_result start_walk(ray_req r);
      cell_result res;
      longint o [3], d [3], lo [3], hi [3];
      longint tnear, tfar, tmin, ta, tb, cs, rel, cell_no, num, t, p;
      res = '{21'd0, ST_MISS};
      walking = 1'b0;
      tnear = 64'sh8000000000000000;
      tfar  = 64'sh7FFFFFFFFFFFFFFF;
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'($signed(r.org[i]));
         d[i] = longint'($signed(r.dir[i]));
         lo[i] = grid_lo[i];
         hi[i] = lo[i] + axis_cells(i) * edge_len(i);
      end
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) return res;
      for (int i = 0; i < 3; i++) begin
         if (d[i] == 0) begin
            if (o[i] < lo[i] || o[i] > hi[i]) return res;
         end else begin
            ta = q_div(lo[i] - o[i], d[i]);
            tb = q_div(hi[i] - o[i], d[i]);
            if ((ta < tb ? ta : tb) > tnear) tnear = ta < tb ? ta : tb;
            if ((ta < tb ? tb : ta) < tfar) tfar = ta < tb ? tb : ta;
         end
      end
      if (tnear > tfar || tfar < 0 || tnear > longint'(ENTRY_LIMIT) * ONE) return res;
      tmin = tnear > 0 ? tnear : 0;
      for (int i = 0; i < 3; i++) begin
         cs = edge_len(i);
         p = tmin > 0 ? o[i] + q_mul(d[i], tmin) : o[i];
         rel = p - lo[i];
         cell_no = rel < 0 ? 0 : rel / cs;
         if (cell_no > axis_cells(i) - 1) cell_no = axis_cells(i) - 1;
         walk_cell[i] = cell_no[7:0];
         walk_neg[i] = d[i] < 0;
         if (d[i] == 0) begin
            cross_step[i] = TIME_SAT;
            cross_at[i] = TIME_SAT;
         end else begin
            cross_step[i] = clamp_dist(q_div(cs, longint'(mag64(d[i]))));
            num = (d[i] < 0 ? cell_no : cell_no + 1) * cs - rel;
            t = q_div(num, d[i]);
            if (t < 0) t = 0;
            cross_at[i] = clamp_dist(tmin + t);
         end
      end
      walking = 1'b1;
      res = '{flat_index(), ST_CELL};
      return res;
   endfunction

   function automatic cell_result step_walk(logic [HIT_W-1:0] hit);
      cell_result res;
      logic [2:0] k;
      int a;
      longint unsigned s;
      res = '{21'd0, ST_LEFT};
      if (!walking) return res;
      k = {cross_at[0] < cross_at[1], cross_at[0] < cross_at[2], cross_at[1] < cross_at[2]};
      a = int'(AXIS_PICK[k]);
      if (hit != HIT_NONE && {1'b0, hit} < cross_at[a]) begin
         walking = 1'b0;
         res.st = ST_HIT;
         return res;
      end
      if (walk_neg[a]) begin
         if (walk_cell[a] == 0) begin
            walking = 1'b0;
            return res;
         end
         walk_cell[a]--;
      end else begin
         if (longint'(walk_cell[a]) + 1 >= axis_cells(a)) begin
            walking = 1'b0;
            return res;
         end
         walk_cell[a]++;
      end
      s = longint'(cross_at[a]) + longint'(cross_step[a]);
      cross_at[a] = s > 64'hFFFFFFFF ? TIME_SAT : s[31:0];
      res = '{flat_index(), ST_CELL};
      return res;
   endfunction

   function automatic cell_result predict_traversal(ray_req r);
      return r.op == OP_START ? start_walk(r) : step_walk(r.hit);
   endfunction

   // receiver stalls follow a mask that changes now and then
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if ($urandom_range(0, 199) == 0) begin
         stall_on <= $urandom_range(0, 2) != 0;
         stall_mask <= 8'($urandom);
      end
      rsp_tready <= reset ? 1'b0 : (stall_on ? stall_mask[cyc[2:0]] : 1'b1);
   end

   always @(posedge clock) begin
      cell_result e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cells.size() == 0) begin
            $error("unexpected transaction idx=%0d status=%0d", rsp_tdata[20:0], rsp_tuser);
            fail_count++;
         end else begin
            e = pending_cells.pop_front();
            status_seen[rsp_tuser]++;
            if (rsp_tdata[20:0] !== e.idx) begin
               $error("cell_index expected %0d actual %0d", e.idx, rsp_tdata[20:0]);
               fail_count++;
            end
            if (rsp_tuser !== e.st) begin
               $error("status expected %0d actual %0d", e.st, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   task automatic issue_req(ray_req r, bit chk = 1'b0, cell_result want = '{21'd0, ST_CELL});
      int gap;
      cell_result e;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         burst_left = $urandom_range(1, 20);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= {1'b0, r.hit, r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
      do @(posedge clock); while (!req_tready);
      e = predict_traversal(r);
      if (chk && (e.idx !== want.idx || e.st !== want.st)) begin
         $error("table row disagrees with prediction");
         fail_count++;
      end
      pending_cells.push_back(chk ? want : e);
      sent_count++;
   endtask

   // hold the sender until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic program_grid(longint lo [3], logic [30:0] sz [3], logic [20:0] rp);
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1'b1;
         csr_addr <= i[2:0];
         csr_wdata <= i < 3 ? lo[i][31:0] : (i < 6 ? {1'b0, sz[i-3]} : {11'd0, rp});
         @(posedge clock);
      end
      csr_we <= 1'b0;
      for (int i = 0; i < 3; i++) begin
         grid_lo[i] = longint'($signed(lo[i][31:0]));
         cell_len[i] = sz[i];
      end
      res_packed = rp;
   endtask

   function automatic ray_req aimed_ray();
      ray_req r;
      longint span, v;
      int sh;
      r.op = OP_START;
      r.hit = HIT_NONE;
      for (int i = 0; i < 3; i++) begin
         span = axis_cells(i) * edge_len(i) + 2 * edge_len(i);
         v = grid_lo[i] - edge_len(i) + longint'({$urandom, $urandom} % span);
         r.org[i] = v[31:0];
         sh = $urandom_range(4, 20);
         v = longint'($urandom_range(0, 1 << sh));
         if ($urandom_range(0, 1)) v = -v;
         if ($urandom_range(0, 7) == 0) v = 0;
         r.dir[i] = v[31:0];
      end
      return r;
   endfunction

   function automatic ray_req noise_ray();
      ray_req r;
      r.op = op_type'($urandom_range(0, 1));
      for (int i = 0; i < 3; i++) begin
         r.org[i] = $urandom;
         r.dir[i] = $urandom;
      end
      r.hit = HIT_W'($urandom);
      return r;
   endfunction

   localparam logic [31:0] HALF = 32'h0000_8000;
   localparam logic [31:0] UNIT = 32'h0001_0000;
   localparam logic [31:0] MUNIT = 32'hFFFF_0000;

   dir_row plan [15] = '{
      '{'{OP_ADVANCE, '{HALF, HALF, HALF}, '{0, 0, 0}, HIT_NONE}, 1, 21'd0, ST_LEFT},
      '{'{OP_START, '{HALF, HALF, HALF}, '{0, 0, 0}, HIT_NONE}, 1, 21'd0, ST_MISS},
      '{'{OP_START, '{HALF, HALF, HALF}, '{UNIT, 0, 0}, HIT_NONE}, 1, 21'd0, ST_CELL},
      '{'{OP_ADVANCE, '{0, 0, 0}, '{0, 0, 0}, HIT_NONE}, 1, 21'd0, ST_LEFT},
      '{'{OP_START, '{HALF, HALF, HALF}, '{UNIT, 0, 0}, HIT_NONE}, 1, 21'd0, ST_CELL},
      '{'{OP_ADVANCE, '{0, 0, 0}, '{0, 0, 0}, 31'd0}, 1, 21'd0, ST_HIT},
      '{'{OP_START, '{32'h0002_0000, HALF, HALF}, '{0, UNIT, 0}, HIT_NONE}, 1, 21'd0, ST_MISS},
      '{'{OP_START, '{32'h0002_0000, HALF, HALF}, '{UNIT, 0, 0}, HIT_NONE}, 1, 21'd0, ST_MISS},
      '{'{OP_START, '{MUNIT, HALF, HALF}, '{UNIT, 0, 0}, HIT_NONE}, 1, 21'd0, ST_CELL},
      '{'{OP_START, '{32'hB1E0_0000, HALF, HALF}, '{UNIT, 0, 0}, HIT_NONE}, 1, 21'd0, ST_MISS},
      '{'{OP_START, '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
          '{32'h80000000, 32'h7FFFFFFF, 32'h80000000}, HIT_NONE}, 0, 21'd0, ST_CELL},
      '{'{OP_START, '{HALF, HALF, HALF}, '{MUNIT, MUNIT, MUNIT}, HIT_NONE}, 1, 21'd0, ST_CELL},
      '{'{OP_ADVANCE, '{0, 0, 0}, '{0, 0, 0}, HIT_NONE}, 1, 21'd0, ST_LEFT},
      '{'{OP_START, '{UNIT, UNIT, UNIT}, '{UNIT, UNIT, UNIT}, HIT_NONE}, 0, 21'd0, ST_CELL},
      '{'{OP_ADVANCE, '{0, 0, 0}, '{0, 0, 0}, 31'h7FFFFFFE}, 0, 21'd0, ST_CELL}
   };

   initial begin
      longint lo [3];
      logic [30:0] sz [3];
      logic [20:0] rp;
      ray_req r;
      int steps, target;
      for (int i = 0; i < 3; i++) begin
         grid_lo[i] = 0;
         cell_len[i] = 31'd65536;
         walk_cell[i] = '0;
         walk_neg[i] = 1'b0;
         cross_at[i] = '0;
         cross_step[i] = '0;
      end
      res_packed = '0;
      walking = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[n]) issue_req(plan[n].rq, plan[n].chk, '{plan[n].idx, plan[n].st});
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 3; i++) begin
            case (ph)
               0: begin
                  lo[i] = 0; sz[i] = 31'd65536;
               end
               1: begin
                  lo[i] = longint'($signed($urandom_range(0, 400 << 16))) - (200 << 16);
                  sz[i] = 31'($urandom_range(1 << 14, 1 << 18));
               end
               2: begin
                  lo[i] = -(64 << 16); sz[i] = 31'd65536;
               end
               3: begin
                  lo[i] = 64'shFFFFFFFF80000000; sz[i] = 31'h7FFFFFFF;
               end
               4: begin
                  lo[i] = 64'sh7FFFFFFF; sz[i] = 31'd1;
               end
               default: begin
                  lo[i] = longint'($signed($urandom)); sz[i] = 31'($urandom);
               end
            endcase
         end
         case (ph)
            0: rp = {7'd3, 7'd3, 7'd3};
            1: rp = 21'($urandom & 21'h0E1C38);
            2: rp = 21'h1FFFFF;
            3: rp = 21'd0;
            default: rp = 21'($urandom);
         endcase
         program_grid(lo, sz, rp);
         target = 15 + (N_ITEMS - 15) * (ph + 1) / 6;
         while (sent_count < target) begin
            if ($urandom_range(0, 9) == 0) begin
               issue_req(noise_ray());
            end else begin
               issue_req(aimed_ray());
               steps = 0;
               while (walking && steps < 200 && sent_count < target) begin
                  r.op = OP_ADVANCE;
                  r.org = '{$urandom, $urandom, $urandom};
                  r.dir = '{$urandom, $urandom, $urandom};
                  case ($urandom_range(0, 9))
                     0, 1: r.hit = HIT_W'($urandom >> $urandom_range(1, 14));
                     2: r.hit = HIT_W'($urandom);
                     default: r.hit = HIT_NONE;
                  endcase
                  issue_req(r);
                  steps++;
               end
               if (!walking && $urandom_range(0, 4) == 0) begin
                  r.op = OP_ADVANCE;
                  r.hit = HIT_W'($urandom);
                  issue_req(r);
               end
            end
            if (ph == 1 && sent_count == target - 100) drain();
         end
         drain();
      end

      $display("covered %0d transactions over 6 grid settings", sent_count);
      $display("results: %0d cells, %0d misses, %0d exits, %0d hits",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (fail_count == 0) begin
         $display("uniform_grid_ray_traversal_core: match");
      end else begin
         $display("uniform_grid_ray_traversal_core: mismatch");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("uniform_grid_ray_traversal_core: mismatch");
      $finish;
   end

endmodule
